[src/tlr_pkg.sv]
package tlr_pkg;

  localparam int unsigned CAPACITY = 128;
  localparam int unsigned ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] STAT_DONE      = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic               opcode;
    logic [7:0]         tag;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] found_value;
    logic [7:0]         entry_count;
  } res_t;

  typedef struct packed {
    logic [7:0]         tag;
    logic signed [31:0] value;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } ctrl_state_e;

endpackage

[src/tlr_ram.sv]
module tlr_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned WIDTH = 40,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/tlr_ctrl.sv]
module tlr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  tlr_pkg::cmd_t     cmd_i,
  output tlr_pkg::mem_req_t mem_req_o,
  input  tlr_pkg::entry_t   mem_rdata_i,
  output logic              res_strobe_o,
  output tlr_pkg::res_t     res_o
);

  import tlr_pkg::*;

  ctrl_state_e       state_q, state_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [7:0]        tag_q, tag_d;
  logic signed [31:0] found_q, found_d;
  logic              strobe_q, strobe_d;
  res_t              res_q, res_d;

  logic              accept;
  logic              full;
  logic              hit;
  logic              more;
  logic [CNT_W-1:0]  idx_next;

  assign accept   = start && (state_q == S_IDLE);
  assign full     = (count_q == CNT_W'(CAPACITY));
  assign hit      = (mem_rdata_i.tag == tag_q);
  assign idx_next = CNT_W'(idx_q) + CNT_W'(1);
  assign more     = (idx_next < count_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (cmd_i.opcode == OP_REMOVE) && (count_q != '0)) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_d = more ? S_SHIFT : S_IDLE;
        end else begin
          state_d = more ? S_SCAN : S_IDLE;
        end
      end
      S_SHIFT: begin
        state_d = more ? S_SHIFT : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    idx_d           = idx_q;
    count_d         = count_q;
    tag_d           = tag_q;
    found_d         = found_q;
    strobe_d        = 1'b0;
    res_d           = res_q;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = count_q[ADDR_W-1:0];
    mem_req_o.wdata = '{tag: cmd_i.tag, value: cmd_i.value};
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          tag_d   = cmd_i.tag;
          found_d = '0;
          idx_d   = '0;
          if (cmd_i.opcode == OP_APPEND) begin
            strobe_d          = 1'b1;
            res_d.found_value = '0;
            if (full) begin
              res_d.status = STAT_FULL;
            end else begin
              mem_req_o.we = 1'b1;
              count_d      = count_q + CNT_W'(1);
              res_d.status = STAT_DONE;
            end
          end else if (count_q == '0) begin
            strobe_d          = 1'b1;
            res_d.status      = STAT_NOT_FOUND;
            res_d.found_value = '0;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          found_d = mem_rdata_i.value;
          if (more) begin
            idx_d = idx_next[ADDR_W-1:0];
          end else begin
            count_d           = count_q - CNT_W'(1);
            strobe_d          = 1'b1;
            res_d.status      = STAT_DONE;
            res_d.found_value = mem_rdata_i.value;
          end
        end else if (more) begin
          idx_d = idx_next[ADDR_W-1:0];
        end else begin
          strobe_d          = 1'b1;
          res_d.status      = STAT_NOT_FOUND;
          res_d.found_value = '0;
        end
      end
      S_SHIFT: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = idx_q - ADDR_W'(1);
        mem_req_o.wdata = mem_rdata_i;
        if (more) begin
          idx_d = idx_next[ADDR_W-1:0];
        end else begin
          count_d           = count_q - CNT_W'(1);
          strobe_d          = 1'b1;
          res_d.status      = STAT_DONE;
          res_d.found_value = found_q;
        end
      end
      default: begin
        idx_d = '0;
      end
    endcase
    if (strobe_d) begin
      res_d.entry_count = 8'(count_d);
    end
    mem_req_o.raddr = idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    tag_q   <= tag_d;
    found_q <= found_d;
    res_q   <= res_d;
  end

  assign busy         = (state_q != S_IDLE);
  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule

[src/tagged_list_remove_first_match_top.sv]
// Ordered tagged list: append at tail, remove first entry matching a tag.
// Command channel: a transaction is taken at a rising edge with start high
// and busy low; cmd_i carries opcode, tag and value.
// Result channel: res_strobe_o is high for one cycle with res_o holding
// status, found_value and entry_count; the receiver cannot stall it.
// Latency: an append, or a remove on an empty list, gives its result in the
// cycle after it is taken and busy never rises.
// A remove walks the list from the head through the single entry memory,
// one entry per cycle: it compares each entry, then on a match moves every
// later entry down one place while continuing the walk. Busy stays high until
// the walk has passed every entry held before the remove (at most CAPACITY);
// the result strobe comes in the cycle busy falls, and a new command may be
// taken in that same cycle.
// Reset: the list is emptied at once by clearing the count; the memory is
// not cleared, as entries beyond the count are never used.
module tagged_list_remove_first_match_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  tlr_pkg::cmd_t  cmd_i,
  output logic           res_strobe_o,
  output tlr_pkg::res_t  res_o
);

  import tlr_pkg::*;

  mem_req_t mem_req;
  entry_t   mem_rdata;

  tlr_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

  tlr_ram #(
    .DEPTH (CAPACITY),
    .WIDTH ($bits(entry_t)),
    .AW    (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

endmodule
